>>> hdl/tksit_pkg.sv
// shared constants, codes and types of the sorted top-k insert table
`default_nettype none

package tksit_pkg;

    localparam int RANKS_DEF      = 3;
    localparam int GROUPS_DEF     = 8;
    localparam int SLOTS_DEF      = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OPCODE_W = 1;
    localparam int GROUP_W  = 3;
    localparam int SLOT_W   = 4;
    localparam int VALUE_W  = 16;
    localparam int RRANK_W  = 2;
    localparam int RTAKEN_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

    localparam logic [RTAKEN_W-1:0] NOT_PLACED = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } tksit_state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic commit;
    } tksit_cmd_t;

    typedef struct packed {
        logic clear_last;
    } tksit_stat_t;

endpackage

`default_nettype wire

>>> hdl/tksit_if.sv
// item and result channel interfaces
`default_nettype none

interface tksit_item_if;
    logic                              valid;
    logic                              ready;
    logic [tksit_pkg::OPCODE_W-1:0]    opcode;
    logic [tksit_pkg::GROUP_W-1:0]     group_index;
    logic [tksit_pkg::SLOT_W-1:0]      slot_index;
    logic [tksit_pkg::VALUE_W-1:0]     new_value;
    logic [tksit_pkg::RRANK_W-1:0]     read_rank;

    modport source (output valid, opcode, group_index, slot_index, new_value, read_rank,
                    input ready);
    modport sink   (input valid, opcode, group_index, slot_index, new_value, read_rank,
                    output ready);
endinterface

interface tksit_result_if;
    logic                              valid;
    logic                              ready;
    logic                              inserted;
    logic [tksit_pkg::RTAKEN_W-1:0]    rank_taken;
    logic                              first_place;
    logic [tksit_pkg::VALUE_W-1:0]     read_value;

    modport source (output valid, inserted, rank_taken, first_place, read_value,
                    input ready);
    modport sink   (input valid, inserted, rank_taken, first_place, read_value,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/top_k_sorted_insert_table_unit.sv
// top level of the sorted top-k insert table
//
// keeps an ascending list of the best RANKS values for every group and slot
// item channel: opcode insert places new_value ahead of the first strictly
//   greater entry, pushing later entries down and dropping the last one;
//   opcode read returns the entry at read_rank
// result channel: one beat per item with inserted, rank_taken, first_place
//   and read_value; an out-of-range group, slot or rank gives the empty result
// each group and slot owns one memory row holding all its ranks, so an item
//   is a read of that row, then a compare, shift and write-back of it
// timing: an item beat loads the item registers and the row read register;
//   the update state then loads the result registers and result valid
// flow: one item at a time, set by the row read-modify-write
//   through the single memory; a new item is taken while a result waits
// reset: a clearing pass writes all ones (no record) into every row, one row
//   a cycle, with item ready low
// stall: a held result keeps the update waiting and item ready stays low
//   until the result beat is taken
`default_nettype none

module top_k_sorted_insert_table_unit #(
    parameter int RANKS      = tksit_pkg::RANKS_DEF,
    parameter int GROUPS     = tksit_pkg::GROUPS_DEF,
    parameter int SLOTS      = tksit_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = tksit_pkg::VALUE_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tksit_item_if.sink    item,
    tksit_result_if.source result
);

    tksit_pkg::tksit_cmd_t  cmd;
    tksit_pkg::tksit_stat_t stat;

    tksit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tksit_dp #(
        .RANKS      (RANKS),
        .GROUPS     (GROUPS),
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (item.opcode),
        .group_index (item.group_index),
        .slot_index  (item.slot_index),
        .new_value   (item.new_value),
        .read_rank   (item.read_rank),
        .inserted    (result.inserted),
        .rank_taken  (result.rank_taken),
        .first_place (result.first_place),
        .read_value  (result.read_value)
    );

endmodule

`default_nettype wire

>>> hdl/tksit_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tksit_ram #(
    parameter int   WIDTH = tksit_pkg::RANKS_DEF * tksit_pkg::VALUE_BITS_DEF,
    parameter int   DEPTH = tksit_pkg::GROUPS_DEF * tksit_pkg::SLOTS_DEF,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/tksit_ctrl.sv
// control state machine: clearing pass, beat acceptance, update and result hand-off
`default_nettype none

module tksit_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire tksit_pkg::tksit_stat_t stat,
    output tksit_pkg::tksit_cmd_t       cmd
);

    tksit_pkg::tksit_state_t state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    can_commit;

    assign can_commit = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tksit_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tksit_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = tksit_pkg::ST_IDLE;
                end
            end
            tksit_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tksit_pkg::ST_UPDATE;
                end
            end
            tksit_pkg::ST_UPDATE:
            begin
                if (can_commit)
                begin
                    state_next = tksit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tksit_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            tksit_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            tksit_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tksit_pkg::ST_UPDATE:
            begin
                cmd.commit = can_commit;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/tksit_dp.sv
// datapath: item registers, list memory, sorted insert and result registers
`default_nettype none

module tksit_dp #(
    parameter int RANKS      = tksit_pkg::RANKS_DEF,
    parameter int GROUPS     = tksit_pkg::GROUPS_DEF,
    parameter int SLOTS      = tksit_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = tksit_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tksit_pkg::tksit_cmd_t               cmd,
    output tksit_pkg::tksit_stat_t                   stat,
    input  wire logic [tksit_pkg::OPCODE_W-1:0]      opcode,
    input  wire logic [tksit_pkg::GROUP_W-1:0]       group_index,
    input  wire logic [tksit_pkg::SLOT_W-1:0]        slot_index,
    input  wire logic [tksit_pkg::VALUE_W-1:0]       new_value,
    input  wire logic [tksit_pkg::RRANK_W-1:0]       read_rank,
    output logic                                     inserted,
    output logic      [tksit_pkg::RTAKEN_W-1:0]      rank_taken,
    output logic                                     first_place,
    output logic      [tksit_pkg::VALUE_W-1:0]       read_value
);

    localparam int ROWS   = GROUPS * SLOTS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RANK_W = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int WORD_W = RANKS * VALUE_BITS;

    logic [ROW_W-1:0]                   clr_cnt_reg;
    logic [tksit_pkg::OPCODE_W-1:0]     op_reg;
    logic [VALUE_BITS-1:0]              val_reg;
    logic [tksit_pkg::RRANK_W-1:0]      rrank_reg;
    logic                               ok_reg;
    logic [ROW_W-1:0]                   row_reg;

    logic                               inserted_reg;
    logic [tksit_pkg::RTAKEN_W-1:0]     rank_taken_reg;
    logic                               first_place_reg;
    logic [tksit_pkg::VALUE_W-1:0]      read_value_reg;

    logic                               inserted_next;
    logic [tksit_pkg::RTAKEN_W-1:0]     rank_taken_next;
    logic                               first_place_next;
    logic [tksit_pkg::VALUE_W-1:0]      read_value_next;

    logic [ROW_W-1:0]                   row_in;
    logic                               ok_in;
    logic [WORD_W-1:0]                  word_rd;
    logic [WORD_W-1:0]                  word_wr;
    logic [VALUE_BITS-1:0]              vals     [RANKS];
    logic [VALUE_BITS-1:0]              new_vals [RANKS];
    logic [RANK_W-1:0]                  pos;
    logic                               placed;
    logic [VALUE_BITS-1:0]              rd_sel;
    logic                               ram_we;
    logic [ROW_W-1:0]                   ram_waddr;
    logic [WORD_W-1:0]                  ram_wdata;

    assign ok_in  = (32'(group_index) < 32'(GROUPS)) && (32'(slot_index) < 32'(SLOTS));
    assign row_in = ROW_W'(32'(group_index) * 32'(SLOTS) + 32'(slot_index));

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ROW_W'(ROWS - 1));

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            val_reg   <= VALUE_BITS'(new_value);
            rrank_reg <= read_rank;
            ok_reg    <= ok_in;
            row_reg   <= row_in;
        end
    end

    always_comb
    begin
        for (int r = 0; r < RANKS; r++)
        begin
            vals[r] = word_rd[r*VALUE_BITS +: VALUE_BITS];
        end
    end

    // first rank holding a strictly greater value
    always_comb
    begin
        pos    = '0;
        placed = 1'b0;
        for (int r = RANKS - 1; r >= 0; r--)
        begin
            if (val_reg < vals[r])
            begin
                pos    = RANK_W'(r);
                placed = 1'b1;
            end
        end
    end

    always_comb
    begin
        new_vals[0] = (placed && (pos == '0)) ? val_reg : vals[0];
        for (int j = 1; j < RANKS; j++)
        begin
            if (placed && (32'(pos) == 32'(j)))
            begin
                new_vals[j] = val_reg;
            end
            else if (placed && (32'(pos) < 32'(j)))
            begin
                new_vals[j] = vals[j-1];
            end
            else
            begin
                new_vals[j] = vals[j];
            end
        end
        for (int j = 0; j < RANKS; j++)
        begin
            word_wr[j*VALUE_BITS +: VALUE_BITS] = new_vals[j];
        end
    end

    always_comb
    begin
        rd_sel = '0;
        for (int r = 0; r < RANKS; r++)
        begin
            if (32'(rrank_reg) == 32'(r))
            begin
                rd_sel = vals[r];
            end
        end
    end

    always_comb
    begin
        inserted_next    = 1'b0;
        rank_taken_next  = tksit_pkg::NOT_PLACED;
        first_place_next = 1'b0;
        read_value_next  = '0;
        if (op_reg == tksit_pkg::OP_READ)
        begin
            if (ok_reg)
            begin
                read_value_next = tksit_pkg::VALUE_W'(rd_sel);
            end
        end
        else if (ok_reg && placed)
        begin
            inserted_next    = 1'b1;
            rank_taken_next  = tksit_pkg::RTAKEN_W'(pos);
            first_place_next = (pos == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            inserted_reg    <= inserted_next;
            rank_taken_reg  <= rank_taken_next;
            first_place_reg <= first_place_next;
            read_value_reg  <= read_value_next;
        end
    end

    assign ram_we    = cmd.clear_wr ||
                       (cmd.commit && ok_reg && placed && (op_reg == tksit_pkg::OP_INSERT));
    assign ram_waddr = cmd.clear_wr ? clr_cnt_reg : row_reg;
    assign ram_wdata = cmd.clear_wr ? {WORD_W{1'b1}} : word_wr;

    tksit_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (row_in),
        .rdata (word_rd)
    );

    assign inserted    = inserted_reg;
    assign rank_taken  = rank_taken_reg;
    assign first_place = first_place_reg;
    assign read_value  = read_value_reg;

endmodule

`default_nettype wire

>>> hdl/tksit_chk.sv
// port-level checker for the sorted top-k insert table, with its bind
`default_nettype none

module tksit_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                inserted,
    input wire logic [tksit_pkg::RTAKEN_W-1:0]      rank_taken,
    input wire logic                                first_place,
    input wire logic [tksit_pkg::VALUE_W-1:0]       read_value
);

    // result beat waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // one item in flight: no item beat right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous item still in work");

    // placement flag agrees with the rank
    a_rank_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inserted == (rank_taken != tksit_pkg::NOT_PLACED)))
        else $error("inserted flag and rank disagree");

    // first place only for rank zero inserts
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_place == (inserted && (rank_taken == '0))))
        else $error("first place flag wrong");

    // a read beat never reports a placement
    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> !inserted)
        else $error("read value on an insert result");

endmodule

bind top_k_sorted_insert_table_unit tksit_chk u_tksit_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .inserted    (result.inserted),
    .rank_taken  (result.rank_taken),
    .first_place (result.first_place),
    .read_value  (result.read_value)
);

`default_nettype wire
